// File: rtl/hgbs_pkg.sv
package hgbs_pkg;

   // Grid geometry: cells live at y * MAX_DIM + x with a fixed row pitch
   localparam int MAX_DIM = 128;
   localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);

   // Field widths
   localparam int CSR_W = 8;
   localparam int POS_W = 16;
   localparam int HGT_W = 32;

   // Operation codes
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_SCAN   = 2'd3
   } op_type;

   // Register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // Last usable index for a size register: 0 acts as 1, above MAX_DIM acts as MAX_DIM
   function automatic logic [DIM_W-1:0] last_index(input logic [CSR_W-1:0] r);
      logic [DIM_W-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (32'(r) > 32'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM - 1);
      end else begin
         res = DIM_W'(r - 1'b1);
      end
      return res;
   endfunction

   // Integer part of Q8.8 lies inside [0, last]
   function automatic logic in_range(input logic [7:0] ip, input logic [DIM_W-1:0] last);
      return !ip[7] && (32'(ip[6:0]) <= 32'(last));
   endfunction

   // Integer part of Q8.8 clamped to [0, last]
   function automatic logic [DIM_W-1:0] clamp_index(input logic [7:0] ip,
                                                     input logic [DIM_W-1:0] last);
      logic [DIM_W-1:0] res;
      if (ip[7]) begin
         res = '0;
      end else if (32'(ip[6:0]) > 32'(last)) begin
         res = last;
      end else begin
         res = DIM_W'(ip[6:0]);
      end
      return res;
   endfunction

   // Linear cell address
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] x,
                                                   input logic [DIM_W-1:0] y);
      return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_DIM) + ADDR_W'(x));
   endfunction

endpackage

// File: rtl/height_grid_bilinear_sampler_unit.sv
// Height grid bilinear sampler.
// Input beats arrive on req_* (valid/ready) carrying an operation, a Q8.8 position
// and a Q24.8 write value; every input beat yields exactly one rsp_* beat.
// Grid size comes from two registers written on csr_*; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// The grid is a single-port memory; one multiply-accumulate unit does all blends.
// A sample does four memory reads, then three blends of a subtract step and a
// multiply-accumulate step each; an extremes scan reads one cell per cycle.
// One item is in flight at a time: a new input beat is taken only once the block
// is back in idle. After reset the block sweeps the whole grid to zero with
// req_ready low, and the size registers go to 128.
// The result sits in an output register: if the receiver holds rsp_ready low,
// the next item is still accepted and worked on, and stalls only when its own
// result is ready and the output register is still full.
module height_grid_bilinear_sampler_unit
   import hgbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [HGT_W-1:0]  req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [HGT_W-1:0]  rsp_height_out,
   output logic signed [HGT_W-1:0]  rsp_max_out,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RWAIT,
      ST_FETCH,
      ST_FLAST,
      ST_BSUB,
      ST_BMAC,
      ST_SCAN,
      ST_SDRAIN,
      ST_DONE
   } state_type;

   state_type                state_ff;
   logic [ADDR_W-1:0]        clr_ff;
   logic [CSR_W-1:0]         width_ff;
   logic [CSR_W-1:0]         height_ff;

   // Latched request
   op_type                   op_ff;
   logic [POS_W-1:0]         px_ff;
   logic [POS_W-1:0]         py_ff;
   logic [HGT_W-1:0]         wval_ff;

   // Sequencer counters
   logic [1:0]               fcnt_ff;
   logic [1:0]               cap_idx_ff;
   logic                     cap_ff;
   logic                     first_ff;
   logic [1:0]               bsel_ff;
   logic [DIM_W-1:0]         sx_ff;
   logic [DIM_W-1:0]         sy_ff;

   // Datapath registers
   logic signed [HGT_W-1:0]  cell_ff [4];
   logic signed [HGT_W-1:0]  ab_ff [2];
   logic signed [HGT_W:0]    diff_ff;
   logic signed [HGT_W-1:0]  base_ff;
   logic [7:0]               frac_ff;
   logic signed [HGT_W-1:0]  res_h_ff;
   logic signed [HGT_W-1:0]  res_m_ff;
   logic                     rsp_valid_ff;
   logic signed [HGT_W-1:0]  rsp_h_ff;
   logic signed [HGT_W-1:0]  rsp_m_ff;
   logic                     rsp_load;

   // Grid memory
   logic [HGT_W-1:0]         mem [DEPTH];
   logic [HGT_W-1:0]         rd_data_ff;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_addr;
   logic [HGT_W-1:0]         mem_wdata;

   // Decoded geometry
   logic [DIM_W-1:0]         wlast;
   logic [DIM_W-1:0]         hlast;
   logic                     in_grid;
   logic [DIM_W-1:0]         x0;
   logic [DIM_W-1:0]         y0;
   logic [DIM_W-1:0]         x1;
   logic [DIM_W-1:0]         y1;

   // Shared blend unit
   logic signed [HGT_W-1:0]  op_a;
   logic signed [HGT_W-1:0]  op_b;
   logic [7:0]               op_f;
   logic signed [41:0]       base_ext;
   logic signed [41:0]       prod;
   logic signed [41:0]       mac_sum;
   logic signed [HGT_W-1:0]  blend_res;
   logic signed [HGT_W-1:0]  rd_s;

   assign wlast   = last_index(width_ff);
   assign hlast   = last_index(height_ff);
   assign in_grid = in_range(px_ff[15:8], wlast) && in_range(py_ff[15:8], hlast);
   assign x0      = clamp_index(px_ff[15:8], wlast);
   assign y0      = clamp_index(py_ff[15:8], hlast);
   assign x1      = (x0 == wlast) ? wlast : DIM_W'(x0 + 1'b1);
   assign y1      = (y0 == hlast) ? hlast : DIM_W'(y0 + 1'b1);
   assign rd_s    = $signed(rd_data_ff);

   // Result moves into the output register when that register is free or its beat is taken in the same cycle
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = wval_ff;
      mem_addr  = cell_addr(x0, y0);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            mem_addr  = clr_ff;
         end
         ST_EXEC: begin
            mem_we = (op_ff == OP_WRITE) && in_grid;
         end
         ST_FETCH: begin
            mem_addr = cell_addr(fcnt_ff[0] ? x1 : x0, fcnt_ff[1] ? y1 : y0);
         end
         ST_SCAN: begin
            mem_addr = cell_addr(sx_ff, sy_ff);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // Blend operand select: two row blends along x, then one along y
   always_comb begin
      case (bsel_ff)
         2'd0: begin
            op_a = cell_ff[0];
            op_b = cell_ff[1];
            op_f = px_ff[7:0];
         end
         2'd1: begin
            op_a = cell_ff[2];
            op_b = cell_ff[3];
            op_f = px_ff[7:0];
         end
         default: begin
            op_a = ab_ff[0];
            op_b = ab_ff[1];
            op_f = py_ff[7:0];
         end
      endcase
   end

   // a*256 + (b-a)*f, then floor shift by 8
   always_comb begin
      base_ext  = 42'(base_ff);
      prod      = 42'(diff_ff) * 42'($signed({1'b0, frac_ff}));
      mac_sum   = (base_ext <<< 8) + prod;
      blend_res = mac_sum[39:8];
   end

   // Sequencer, config registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         width_ff     <= CSR_W'(128);
         height_ff    <= CSR_W'(128);
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
         first_ff     <= 1'b0;
         fcnt_ff      <= '0;
         bsel_ff      <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
               CSR_GRID_HEIGHT: height_ff <= csr_wdata;
               default:         width_ff  <= width_ff;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         cap_ff <= (state_ff == ST_FETCH) || (state_ff == ST_SCAN);

         // capture fetched cells for a sample
         if (cap_ff && ((state_ff == ST_FETCH) || (state_ff == ST_FLAST))) begin
            cell_ff[cap_idx_ff] <= rd_s;
         end

         // running extremes for a scan
         if (cap_ff && ((state_ff == ST_SCAN) || (state_ff == ST_SDRAIN))) begin
            first_ff <= 1'b0;
            if (first_ff || (rd_s < res_h_ff)) begin
               res_h_ff <= rd_s;
            end
            if (first_ff || (rd_s > res_m_ff)) begin
               res_m_ff <= rd_s;
            end
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= ADDR_W'(clr_ff + 1'b1);
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= op_type'(req_operation);
                  px_ff    <= req_pos_x;
                  py_ff    <= req_pos_y;
                  wval_ff  <= req_write_value;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               res_h_ff <= '0;
               res_m_ff <= '0;
               fcnt_ff  <= '0;
               bsel_ff  <= '0;
               sx_ff    <= '0;
               sy_ff    <= '0;
               first_ff <= 1'b1;
               unique case (op_ff)
                  OP_WRITE:  state_ff <= ST_DONE;
                  OP_READ:   state_ff <= ST_RWAIT;
                  OP_SAMPLE: state_ff <= ST_FETCH;
                  OP_SCAN:   state_ff <= ST_SCAN;
                  default:   state_ff <= ST_DONE;
               endcase
            end
            ST_RWAIT: begin
               res_h_ff <= in_grid ? rd_s : '0;
               state_ff <= ST_DONE;
            end
            ST_FETCH: begin
               cap_idx_ff <= fcnt_ff;
               fcnt_ff    <= 2'(fcnt_ff + 1'b1);
               if (fcnt_ff == 2'd3) begin
                  state_ff <= ST_FLAST;
               end
            end
            ST_FLAST: begin
               state_ff <= ST_BSUB;
            end
            ST_BSUB: begin
               diff_ff  <= (HGT_W+1)'(op_b) - (HGT_W+1)'(op_a);
               base_ff  <= op_a;
               frac_ff  <= op_f;
               state_ff <= ST_BMAC;
            end
            ST_BMAC: begin
               if (bsel_ff == 2'd2) begin
                  res_h_ff <= blend_res;
                  state_ff <= ST_DONE;
               end else begin
                  ab_ff[bsel_ff[0]] <= blend_res;
                  bsel_ff           <= 2'(bsel_ff + 1'b1);
                  state_ff          <= ST_BSUB;
               end
            end
            ST_SCAN: begin
               if (sx_ff == wlast) begin
                  sx_ff <= '0;
                  if (sy_ff == hlast) begin
                     state_ff <= ST_SDRAIN;
                  end else begin
                     sy_ff <= DIM_W'(sy_ff + 1'b1);
                  end
               end else begin
                  sx_ff <= DIM_W'(sx_ff + 1'b1);
               end
            end
            ST_SDRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_h_ff <= res_h_ff;
                  rsp_m_ff <= res_m_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = rsp_h_ff;
   assign rsp_max_out    = rsp_m_ff;

endmodule

// File: rtl/hgbs_checker.sv
module hgbs_checker
   import hgbs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [HGT_W-1:0]  rsp_height_out,
   input logic signed [HGT_W-1:0]  rsp_max_out
);

   // Grid clear keeps both channels quiet right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!req_ready && !rsp_valid))
      else $error("channel active during grid clear");

   // Only one item in flight: ready drops after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat accepted while busy");

   // A new result only appears as the block returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result posted while still busy");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_height_out) && $stable(rsp_max_out)))
      else $error("result beat changed while stalled");

endmodule

bind height_grid_bilinear_sampler_unit hgbs_checker u_hgbs_checker (.*);
